@@ hw/rtl/satq_pkg.sv @@
// Package for the sorted alarm timer queue.
// Holds the item, result and command types and the operation and status codes.
// No dependencies.
package satq_pkg;

	// Operation codes of an input item.
	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_POP      = 1'b1;

	// Status codes of a result item.
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_POPPED   = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	// Configuration register indexes.
	localparam logic REG_TICK_PERIOD = 1'b0;

	localparam logic [15:0] PERIOD_RESET = 16'd100;
	localparam int DIV_STEPS = 31;
	localparam int STEP_W    = 5;

	typedef struct packed {
		logic        operation;
		logic [46:0] now_tick;
		logic [30:0] delay;
		logic [15:0] alarm_tag;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] due_tag;
		logic [47:0] trigger_at;
	} result_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic        is_pop;
		logic [46:0] now_tick;
		logic [30:0] delay;
		logic [15:0] alarm_tag;
	} cmd_t;

	typedef struct packed {
		logic [47:0] trig;
		logic [15:0] tag;
	} entry_t;

endpackage

@@ hw/rtl/satq_front.sv @@
// Front end of the alarm queue: a two-entry request queue that classifies requests.
// Depends on satq_pkg.
module satq_front import satq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  cmd_valid,
	output cmd_t  cmd,
	input  logic  cmd_take
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_take;
	item_t      head;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_take   = cmd_take && cmd_valid;
	assign head      = slot_q[rd_ptr_q];

	// Classify the oldest request by its operation.
	always_comb begin
		cmd.is_pop    = (head.operation == OP_POP);
		cmd.now_tick  = head.now_tick;
		cmd.delay     = head.delay;
		cmd.alarm_tag = head.alarm_tag;
	end

	// Request storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_take) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

endmodule

@@ hw/rtl/satq_div.sv @@
// Restoring divider, one quotient bit per cycle, for delay divided by tick period.
// Depends on satq_pkg.
module satq_div import satq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [30:0] quotient
);

	logic [30:0]       dvd_q;
	logic [15:0]       rem_q;
	logic [15:0]       div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [16:0]       trial;
	logic              fits;

	assign trial    = {rem_q, dvd_q[30]};
	assign fits     = (trial >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	// Datapath: dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= 16'd0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			dvd_q <= {dvd_q[29:0], fits};
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/satq_back.sv @@
// Back end of the alarm queue: sorted store in a circular memory, its sequencer
// and the result register. Depends on satq_pkg and satq_div.
module satq_back import satq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_take,
	input  logic [15:0] period,
	output logic        empty,
	input  logic        pop,
	output result_t     result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_DIV       = 7'b0000010,
		S_INS_START = 7'b0000100,
		S_INS_CMP   = 7'b0001000,
		S_INS_LAST  = 7'b0010000,
		S_POP_CMP   = 7'b0100000,
		S_RESP      = 7'b1000000
	} state_t;

	state_t          state_q;
	entry_t          mem_q [QUEUE_DEPTH];
	entry_t          rdata_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [47:0]     trig_q;
	logic [15:0]     tag_q;
	logic [46:0]     now_q;
	result_t         res_q;
	result_t         out_q;
	logic            out_valid_q;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            wr_en;
	logic            div_start;
	logic            div_done;
	logic [30:0]     div_quot;
	logic [15:0]     divisor;
	logic            is_full;
	logic            cmp_gt;
	logic            pop_due;

	// Physical slot of logical position i counted from the head.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW + 1)'(h) + {1'b0, i};
		if (s >= (CW + 1)'(QUEUE_DEPTH)) s = s - (CW + 1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	assign divisor = (period == 16'd0) ? 16'd1 : period;
	assign is_full = (count_q == CW'(QUEUE_DEPTH));
	assign cmp_gt  = (rdata_q.trig > trig_q);
	assign pop_due = (rdata_q.trig <= {1'b0, now_q});
	assign empty   = !out_valid_q;
	assign result  = out_q;

	satq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.delay),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Memory addressing and request take.
	always_comb begin
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = phys(head_q, idx_q + 1'b1);
		wr_data   = '{trig: trig_q, tag: tag_q};
		cmd_take  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_take  = cmd_valid;
				div_start = cmd_valid && !cmd.is_pop && !is_full;
			end
			S_INS_START: begin
				if (count_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = head_q;
				end else begin
					rd_addr = phys(head_q, count_q - 1'b1);
				end
			end
			S_INS_CMP: begin
				wr_en = 1'b1;
				if (cmp_gt) begin
					wr_data = rdata_q;
					if (idx_q != '0) rd_addr = phys(head_q, idx_q - 1'b1);
				end
			end
			S_INS_LAST: begin
				wr_en   = 1'b1;
				wr_addr = head_q;
			end
			S_DIV, S_POP_CMP, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Alarm store with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rdata_q <= mem_q[rd_addr];
	end

	// Request payload and pending result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			now_q <= cmd.now_tick;
			tag_q <= cmd.alarm_tag;
			if (cmd.is_pop || is_full) begin
				res_q <= '{status: cmd.is_pop ? ST_NONE : ST_FULL,
					due_tag: 16'd0, trigger_at: 48'd0};
			end
		end
		if (state_q == S_DIV && div_done) begin
			trig_q <= {1'b0, now_q} + {17'd0, div_quot} + 48'd1;
		end
		if (state_q == S_INS_START) begin
			idx_q <= count_q - 1'b1;
			res_q <= '{status: ST_INSERTED, due_tag: tag_q, trigger_at: trig_q};
		end
		if (state_q == S_INS_CMP && cmp_gt && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (state_q == S_POP_CMP) begin
			res_q <= pop_due ? '{status: ST_POPPED, due_tag: rdata_q.tag,
				trigger_at: rdata_q.trig} : '{status: ST_NONE, due_tag: 16'd0,
				trigger_at: 48'd0};
		end
		if (state_q == S_RESP && (!out_valid_q || pop)) begin
			out_q <= res_q;
		end
	end

	// Sequencer, store bookkeeping and result register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result refills the register in the cycle the old one leaves.
			if (state_q == S_RESP && (!out_valid_q || pop)) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.is_pop) begin
							state_q <= (count_q == '0) ? S_RESP : S_POP_CMP;
						end else begin
							state_q <= is_full ? S_RESP : S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_INS_START;
				end
				S_INS_START: begin
					if (count_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (!cmp_gt) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end else if (idx_q == '0) begin
						state_q <= S_INS_LAST;
					end
				end
				S_INS_LAST: begin
					count_q <= count_q + 1'b1;
					state_q <= S_RESP;
				end
				S_POP_CMP: begin
					if (pop_due) begin
						head_q  <= phys(head_q, CW'(1));
						count_q <= count_q - 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || pop) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The store never holds more alarms than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("alarm count exceeds queue depth");

	// A request is taken from the front only while the sequencer is idle.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == S_IDLE)
		else $error("request taken while busy");

	// A due pop removes exactly one alarm.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_CMP && pop_due) |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not remove one alarm");

endmodule

@@ hw/rtl/sorted_alarm_timer_queue.sv @@
// Sorted alarm timer queue. Requests enter a two-entry queue and are handled one
// at a time. A register request runs the one-bit-a-cycle divider of delay by tick
// period, then moves each stored alarm that is due later than the new one a place
// further from the head in the memory, one per cycle, to open the sorted slot. A
// register request into a full store is rejected. A result that is not taken holds
// the sequencer. The store needs no clearing after reset. The tick period register
// sits at byte address 0; a period of 0 acts as 1.
module sorted_alarm_timer_queue import satq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result
);

	logic [15:0] period_q;
	logic        cmd_valid;
	logic        cmd_take;
	cmd_t        cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TICK_PERIOD) ? {16'd0, period_q} : 32'd0;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TICK_PERIOD) begin
			period_q <= pwdata[15:0];
		end
	end

	satq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	satq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.period    (period_q),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
